[hw/rtl/lfua_pkg.sv]
// Package for the lowest free unit interval allocator.
// Holds the control state encoding and the command codes shared by the RTL.
// No dependencies.
package lfua_pkg;

    // Command carried in the input tuser bit
    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

[hw/rtl/lfua_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Single clock; no reset on the storage or the read register. No dependencies.
module lfua_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_BITS-1:0]     wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_BITS-1:0]     rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on enable, registered read on enable
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/lowest_free_unit_interval_allocator_core.sv]
// Top level of the lowest free unit interval allocator.
// Uses lfua_pkg for state and command codes and two lfua_ram instances for
// the per-unit end times and use counts.
//
// Channel   Dir  Ports          Contents (lowest bit first)
// s_axis    in   tdata, tuser   tdata: start_time, end_time; tuser: func
// m_axis    out  tdata, tuser   tdata: unit_index, unit_uses, units_opened;
//                               tuser: table_full
//
// An allocate item goes through capture, start, the scan and output load. The
// scan reads one stored end time per cycle, compares each registered read, and
// stops at the first free unit. A clear item goes through capture, start and
// output load. One item is in work at a time; the next input transfer is taken
// while a finished result still waits on m_axis, and output load holds while
// m_axis is stalled.
// Reset (aresetn low, synchronous) closes all units; use counts of units
// opened later start from zero, so no clearing pass is run.
module lowest_free_unit_interval_allocator_core #(
    parameter int MAX_UNITS  = 64,
    parameter int TIME_BITS  = 20,
    parameter int COUNT_BITS = 16,
    localparam int IDX_BITS      = $clog2(MAX_UNITS + 1),
    localparam int IN_DATA_BITS  = ((2 * TIME_BITS + 7) / 8) * 8,
    localparam int OUT_RAW_BITS  = 2 * IDX_BITS + COUNT_BITS,
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input channel
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // start_time, end_time, zero pad
    input  logic                     s_axis_tuser,   // func
    // Result channel
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // unit_index, unit_uses,
                                                     // units_opened, zero pad
    output logic                     m_axis_tuser    // table_full
);

    localparam int ADDR_BITS = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam logic [IDX_BITS-1:0]   FULL_COUNT = IDX_BITS'(MAX_UNITS);
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

    // Control state
    lfua_pkg::state_t state_reg, state_next;
    logic [IDX_BITS-1:0]  opened_reg, opened_next;
    logic [IDX_BITS-1:0]  scan_idx_reg, scan_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [ADDR_BITS-1:0] cmp_idx_reg, cmp_idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // Payload registers
    lfua_pkg::func_t      func_reg, func_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] end_reg, end_next;
    logic [IDX_BITS-1:0]   res_index_reg, res_index_next;
    logic [COUNT_BITS-1:0] res_uses_reg, res_uses_next;
    logic [IDX_BITS-1:0]   res_opened_reg, res_opened_next;
    logic                  res_full_reg, res_full_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    // RAM ports
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic [TIME_BITS-1:0]  end_rd_data;
    logic [COUNT_BITS-1:0] cnt_rd_data;

    logic                  hit;
    logic                  more;
    logic                  out_free;
    logic [COUNT_BITS-1:0] cnt_inc;

    // Per-unit end times
    lfua_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_UNITS)
    ) u_end_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (end_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (end_rd_data)
    );

    // Per-unit use counts, read alongside the end times
    lfua_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_UNITS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cnt_rd_data)
    );

    // Compare the returned entry, check for entries left to read
    assign hit      = cmp_valid_reg && (end_rd_data <= start_reg);
    assign more     = scan_idx_reg < opened_reg;
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign cnt_inc  = (cnt_rd_data == {COUNT_BITS{1'b1}}) ? cnt_rd_data
                                                          : cnt_rd_data + COUNT_ONE;

    // Hold state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lfua_pkg::ST_IDLE;
            opened_reg    <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            opened_reg    <= opened_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg    <= cmp_idx_next;
        func_reg       <= func_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        res_index_reg  <= res_index_next;
        res_uses_reg   <= res_uses_next;
        res_opened_reg <= res_opened_next;
        res_full_reg   <= res_full_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // Sequence capture, scan, update and output load
    always_comb begin
        state_next      = state_reg;
        opened_next     = opened_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        func_next       = func_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        res_index_next  = res_index_reg;
        res_uses_next   = res_uses_reg;
        res_opened_next = res_opened_reg;
        res_full_next   = res_full_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        s_axis_tready   = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = scan_idx_reg[ADDR_BITS-1:0];
        wr_en           = 1'b0;
        wr_addr         = cmp_idx_reg;
        cnt_wr_data     = cnt_inc;

        unique case (state_reg)
            lfua_pkg::ST_IDLE: begin
                // Take the next transfer, even with a result still waiting
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    func_next  = lfua_pkg::func_t'(s_axis_tuser);
                    start_next = s_axis_tdata[TIME_BITS-1:0];
                    end_next   = s_axis_tdata[2*TIME_BITS-1:TIME_BITS];
                    state_next = lfua_pkg::ST_START;
                end
            end

            lfua_pkg::ST_START: begin
                if (func_reg == lfua_pkg::FUNC_CLEAR) begin
                    // Close all units; counts of reopened units restart at zero
                    opened_next     = '0;
                    res_index_next  = '0;
                    res_uses_next   = '0;
                    res_opened_next = '0;
                    res_full_next   = 1'b0;
                    state_next      = lfua_pkg::ST_OUT;
                end else begin
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = lfua_pkg::ST_SCAN;
                end
            end

            lfua_pkg::ST_SCAN: begin
                if (hit) begin
                    // Reuse the lowest free unit: store end, bump count
                    wr_en           = 1'b1;
                    wr_addr         = cmp_idx_reg;
                    cnt_wr_data     = cnt_inc;
                    res_index_next  = IDX_BITS'(cmp_idx_reg) + IDX_BITS'(1);
                    res_uses_next   = cnt_inc;
                    res_opened_next = opened_reg;
                    res_full_next   = 1'b0;
                    state_next      = lfua_pkg::ST_OUT;
                end else if (more) begin
                    // Issue the read of the next opened unit
                    rd_en          = 1'b1;
                    rd_addr        = scan_idx_reg[ADDR_BITS-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[ADDR_BITS-1:0];
                    scan_idx_next  = scan_idx_reg + IDX_BITS'(1);
                end else if (opened_reg == FULL_COUNT) begin
                    // No free unit and none left to open
                    res_index_next  = '0;
                    res_uses_next   = '0;
                    res_opened_next = opened_reg;
                    res_full_next   = 1'b1;
                    state_next      = lfua_pkg::ST_OUT;
                end else begin
                    // Open the next unit with a first use
                    wr_en           = 1'b1;
                    wr_addr         = opened_reg[ADDR_BITS-1:0];
                    cnt_wr_data     = COUNT_ONE;
                    opened_next     = opened_reg + IDX_BITS'(1);
                    res_index_next  = opened_reg + IDX_BITS'(1);
                    res_uses_next   = COUNT_ONE;
                    res_opened_next = opened_reg + IDX_BITS'(1);
                    res_full_next   = 1'b0;
                    state_next      = lfua_pkg::ST_OUT;
                end
            end

            lfua_pkg::ST_OUT: begin
                // Load the output register once it is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_BITS'({res_opened_reg, res_uses_reg,
                                                    res_index_reg});
                    m_tuser_next  = res_full_reg;
                    state_next    = lfua_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lfua_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule

[sim/tb.sv]
// Self-checking testbench for lowest_free_unit_interval_allocator_core.
// Depends on lfua_pkg and the core RTL; a scoreboard class predicts each result
// from the accepted input transfers and checks the result channel in order.
module tb;

    localparam int MAX_UNITS   = 64;
    localparam int TIME_BITS   = 20;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_BITS    = 7;
    localparam int TIME_MAX    = (1 << TIME_BITS) - 1;
    localparam int RANDOM_ITEMS = 1040;
    localparam int STEADY_ITEMS = 40;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT = 2500000;

    typedef struct packed {
        logic [IDX_BITS-1:0]   unit_index;
        logic [COUNT_BITS-1:0] unit_uses;
        logic [IDX_BITS-1:0]   units_opened;
        logic                  table_full;
    } alloc_result_t;

    // Predicts allocator results and checks them against the result channel
    class alloc_scoreboard;
        logic [TIME_BITS-1:0]  free_at [MAX_UNITS];
        logic [COUNT_BITS-1:0] use_count [MAX_UNITS];
        int unsigned           open_units;
        alloc_result_t         pending_q[$];
        int unsigned           errors;
        int unsigned           checked;
        int unsigned           clears;
        int unsigned           full_hits;
        int unsigned           peak_open;
        int unsigned           saturated_hits;

        function new();
            foreach (use_count[i]) use_count[i] = '0;
            open_units = 0;
            errors = 0;
            checked = 0;
            clears = 0;
            full_hits = 0;
            peak_open = 0;
            saturated_hits = 0;
        endfunction

        // Work out the result of one accepted input transfer and queue it
        function void note_input(lfua_pkg::func_t f, logic [TIME_BITS-1:0] st,
                                 logic [TIME_BITS-1:0] en);
            alloc_result_t r;
            int pick;
            r = '0;
            pick = -1;
            if (f == lfua_pkg::FUNC_CLEAR) begin
                foreach (use_count[i]) use_count[i] = '0;
                open_units = 0;
                clears++;
            end else begin
                // lowest opened unit that is free by the start time
                for (int i = 0; i < open_units; i++) begin
                    if (pick < 0 && free_at[i] <= st) pick = i;
                end
                if (pick < 0 && open_units == MAX_UNITS) begin
                    r.units_opened = IDX_BITS'(open_units);
                    r.table_full   = 1'b1;
                end else begin
                    if (pick < 0) begin
                        pick = open_units;
                        open_units++;
                    end
                    free_at[pick] = en;
                    if (use_count[pick] != '1) use_count[pick]++;
                    else saturated_hits++;
                    r.unit_index   = IDX_BITS'(pick + 1);
                    r.unit_uses    = use_count[pick];
                    r.units_opened = IDX_BITS'(open_units);
                end
                if (open_units > peak_open) peak_open = open_units;
            end
            pending_q.insert(pending_q.size(), r);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(logic [31:0] data, logic full);
            alloc_result_t want, got;
            bit bad;
            got.unit_index   = data[IDX_BITS-1:0];
            got.unit_uses    = data[IDX_BITS+COUNT_BITS-1:IDX_BITS];
            got.units_opened = data[2*IDX_BITS+COUNT_BITS-1:IDX_BITS+COUNT_BITS];
            got.table_full   = full;
            checked++;
            if (got.table_full === 1'b1) full_hits++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d arrived with nothing predicted: unit %0d uses %0d",
                             checked, got.unit_index, got.unit_uses);
                return;
            end
            want = pending_q.pop_front();
            bad = (got.unit_index !== want.unit_index)
               || (got.unit_uses !== want.unit_uses)
               || (got.units_opened !== want.units_opened)
               || (got.table_full !== want.table_full);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %0d mismatch: expected unit %0d uses %0d opened %0d full %0b",
                             checked, want.unit_index, want.unit_uses,
                             want.units_opened, want.table_full);
                    $display("    got unit %0d uses %0d opened %0d full %0b",
                             got.unit_index, got.unit_uses, got.units_opened,
                             got.table_full);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    alloc_scoreboard board = new();

    int unsigned items_sent = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    bit          rx_steady = 1'b0;
    bit          hold_request = 1'b0;

    lowest_free_unit_interval_allocator_core #(
        .MAX_UNITS (MAX_UNITS),
        .TIME_BITS (TIME_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one item, opening a new burst after a random gap when the last one ran out
    task automatic offer(input lfua_pkg::func_t f, input logic [TIME_BITS-1:0] st,
                         input logic [TIME_BITS-1:0] en);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {en, st};
        s_axis_tuser  <= f;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_input(f, st, en);
        items_sent++;
    endtask

    // Receiver: stall in runs of random length, with one long hold-off on request
    initial begin : receiver
        int run_left;
        bit level;
        int pick;
        run_left = 0;
        level = 1'b1;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (run_left == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    level = 1'b0;
                    run_left = $urandom_range(1, 8);
                end else if (pick < 8) begin
                    level = 1'b1;
                    run_left = $urandom_range(1, 6);
                end else begin
                    level = 1'b1;
                    run_left = $urandom_range(20, 60);
                end
            end
            run_left--;
            m_axis_tready <= rx_steady ? 1'b1 : level;
        end
    end

    // Check every result transfer
    initial begin : result_monitor
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Bound the run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycles, board.pending_q.size());
        $display("lowest_free_unit_interval_allocator_core test failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned t;
        int unsigned step;
        int unsigned dur;
        int unsigned target;
        int unsigned hold_at;
        int          kind;
        int          n;
        bit          first_batch;
        bit          hold_issued;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= lfua_pkg::FUNC_ALLOC;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, reuse, end before start, late start, clears
        offer(lfua_pkg::FUNC_ALLOC, 20'h00000, 20'h00000);
        offer(lfua_pkg::FUNC_ALLOC, 20'h00000, 20'hFFFFF);
        offer(lfua_pkg::FUNC_ALLOC, 20'h00005, 20'h00003);
        offer(lfua_pkg::FUNC_ALLOC, 20'h00004, 20'h0000A);
        offer(lfua_pkg::FUNC_ALLOC, 20'h00009, 20'h00014);
        offer(lfua_pkg::FUNC_ALLOC, 20'h0000A, 20'hAAAAA);
        offer(lfua_pkg::FUNC_ALLOC, 20'hFFFFF, 20'h55555);
        offer(lfua_pkg::FUNC_CLEAR, 20'hFFFFF, 20'hFFFFF);
        offer(lfua_pkg::FUNC_CLEAR, 20'h00000, 20'h00000);
        offer(lfua_pkg::FUNC_ALLOC, 20'hFFFFF, 20'h00000);
        offer(lfua_pkg::FUNC_ALLOC, 20'h00000, 20'hFFFFF);
        offer(lfua_pkg::FUNC_ALLOC, 20'h00000, 20'h00000);

        // Random batches; the first one fills the table
        target = items_sent + RANDOM_ITEMS;
        hold_at = items_sent + $urandom_range(150, 600);
        hold_issued = 1'b0;
        first_batch = 1'b1;
        while (items_sent < target) begin
            if (!hold_issued && items_sent >= hold_at) begin
                hold_request = 1'b1;
                hold_issued = 1'b1;
            end
            kind = first_batch ? 5 : $urandom_range(0, 9);
            first_batch = 1'b0;
            if (kind <= 4 || kind >= 8) begin
                // ordered batch with short intervals; sometimes no clear up front
                if (kind <= 4)
                    offer(lfua_pkg::FUNC_CLEAR, 20'($urandom), 20'($urandom));
                n = $urandom_range(10, 60);
                t = $urandom_range(0, 1) ? $urandom_range(0, TIME_MAX)
                                         : $urandom_range(0, 1000);
                for (int k = 0; k < n; k++) begin
                    step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    t = (t + step > TIME_MAX) ? TIME_MAX : t + step;
                    dur = $urandom_range(0, 300);
                    offer(lfua_pkg::FUNC_ALLOC, TIME_BITS'(t), TIME_BITS'(t + dur));
                end
            end else if (kind <= 6) begin
                // long intervals pile up until the table is full
                offer(lfua_pkg::FUNC_CLEAR, 20'($urandom), 20'($urandom));
                n = $urandom_range(66, 75);
                t = $urandom_range(0, 100);
                for (int k = 0; k < n; k++) begin
                    t = t + $urandom_range(0, 2);
                    offer(lfua_pkg::FUNC_ALLOC, TIME_BITS'(t),
                          TIME_BITS'(TIME_MAX - $urandom_range(0, 15)));
                end
            end else begin
                // noise: any times, in any order, with stray clears
                n = $urandom_range(5, 20);
                for (int k = 0; k < n; k++) begin
                    offer(($urandom_range(0, 7) == 0) ? lfua_pkg::FUNC_CLEAR
                                                      : lfua_pkg::FUNC_ALLOC,
                          20'($urandom), 20'($urandom));
                end
            end
        end

        // Finish with a back-to-back run on one unit and a steady receiver
        no_gaps = 1'b1;
        rx_steady = 1'b1;
        offer(lfua_pkg::FUNC_CLEAR, 20'h00000, 20'h00000);
        for (int k = 0; k < STEADY_ITEMS; k++)
            offer(lfua_pkg::FUNC_ALLOC, 20'h00000, 20'h00000);
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then let the core settle
        while (board.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input transfers and %0d results, %0d clears, %0d full-table hits",
                 items_sent, board.checked, board.clears, board.full_hits);
        $display("peak of %0d units open, %0d allocations at a saturated use count, %0d errors",
                 board.peak_open, board.saturated_hits, board.errors);
        if (board.errors == 0)
            $display("lowest_free_unit_interval_allocator_core test passed");
        else
            $display("lowest_free_unit_interval_allocator_core test failed");
        $finish;
    end
endmodule

[files.f]
hw/rtl/lfua_pkg.sv
hw/rtl/lfua_ram.sv
hw/rtl/lowest_free_unit_interval_allocator_core.sv
sim/tb.sv
